FILE: sv/fshpd_pkg.sv
// Package for the four-step heterodyne phase decoder.
// Holds shared constants, the arctangent table and status codes; no dependencies.
package fshpd_pkg;

  localparam int unsigned DefaultFractionBits = 16;
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CordicPreshift = 20;
  localparam int unsigned CordicWidth = 32;
  localparam logic [7:0] ThresholdReset = 8'd10;
  localparam logic [15:0] OutFullScale = 16'd65280;

  typedef enum logic [1:0] {
    STATUS_DECODED = 2'd0,
    STATUS_SHADOW  = 2'd1,
    STATUS_FLAT    = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } ctrl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;     5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;       5'd21: r = 32'd325;
      5'd22: r = 32'd162;       5'd23: r = 32'd81;
      5'd24: r = 32'd40;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/fshpd_if.sv
// Stream interfaces for the phase decoder: pixel input and phase output.
// Has no dependencies; pixel_status is a plain 2-bit field.
interface fshpd_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  white_level;
  logic [7:0]  black_level;
  logic [31:0] group_a_samples;
  logic [31:0] group_b_samples;
  logic [31:0] group_c_samples;
  modport source (output valid, white_level, black_level, group_a_samples,
                  group_b_samples, group_c_samples, input ready);
  modport sink (input valid, white_level, black_level, group_a_samples,
                group_b_samples, group_c_samples, output ready);
endinterface

interface fshpd_phase_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_out;
  logic [1:0]  pixel_status;
  modport source (output valid, phase_out, pixel_status, input ready);
  modport sink (input valid, phase_out, pixel_status, output ready);
endinterface

FILE: sv/four_step_heterodyne_phase_decode_unit.sv
// Top level of the four-step heterodyne phase decoder.
// Depends on fshpd_pkg, fshpd_if, fshpd_lane and fshpd_merge.
//
// One pixel transaction enters on the pix channel: white and black levels and
// three groups of four 8-bit phase samples. One transaction leaves on the res
// channel with the unwrapped phase (8.8 fixed point, 0..255) and a status.
// Three CORDIC lanes compute the wrapped phases side by side, one per group,
// and a merge stage unwraps them by heterodyne differences.
// Throughput: one pixel per cycle while the output is not stalled. From
// acceptance to the output register a pixel passes an entry register, the
// 28-stage CORDIC pipeline, a rounding register and three merge stages.
// The whole pipeline advances only while the output register is empty or
// being taken, so a stalled receiver holds every stage and pix.ready drops.
// Reset clears the valid bits of the pipeline and loads the contrast
// threshold with 10; cfg_we writes it.
module four_step_heterodyne_phase_decode_unit #(
  parameter int unsigned PHASE_FRACTION_BITS = fshpd_pkg::DefaultFractionBits
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  fshpd_pixel_if.sink       pix,
  fshpd_phase_if.source     res
);
  import fshpd_pkg::*;

  localparam int unsigned LaneDepth = CordicSteps + 2;

  logic [7:0] threshold;
  logic en;
  logic [LaneDepth-1:0] vld;
  status_t st [LaneDepth];
  status_t st0;
  logic [8:0] diff;
  logic [PHASE_FRACTION_BITS-1:0] pa, pb, pc;
  logic fa, fb, fc;
  ctrl_t mctrl, octrl;

  assign en = !res.valid || res.ready;
  assign pix.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  assign diff = {1'b0, pix.white_level} - {1'b0, pix.black_level};
  assign st0 = (pix.white_level <= pix.black_level || diff[7:0] <= threshold) ?
               STATUS_SHADOW : STATUS_DECODED;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LaneDepth-2:0], pix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0;
      for (int i = 1; i < LaneDepth; i++) begin
        st[i] <= st[i-1];
      end
    end
  end

  fshpd_lane #(.FRAC_BITS(PHASE_FRACTION_BITS)) u_lane_a (
    .clk(clk), .en(en), .samples(pix.group_a_samples), .phase(pa), .flat(fa));
  fshpd_lane #(.FRAC_BITS(PHASE_FRACTION_BITS)) u_lane_b (
    .clk(clk), .en(en), .samples(pix.group_b_samples), .phase(pb), .flat(fb));
  fshpd_lane #(.FRAC_BITS(PHASE_FRACTION_BITS)) u_lane_c (
    .clk(clk), .en(en), .samples(pix.group_c_samples), .phase(pc), .flat(fc));

  always_comb begin
    mctrl.valid = vld[LaneDepth-1];
    priority if (st[LaneDepth-1] == STATUS_SHADOW) begin
      mctrl.status = STATUS_SHADOW;
    end else if (fa || fb || fc) begin
      mctrl.status = STATUS_FLAT;
    end else begin
      mctrl.status = STATUS_DECODED;
    end
  end

  fshpd_merge #(.FRAC_BITS(PHASE_FRACTION_BITS)) u_merge (
    .clk(clk), .en(en), .ctrl_in(mctrl), .p1(pa), .p2(pb), .p3(pc),
    .ctrl_out(octrl), .phase_out(res.phase_out));

  logic [2:0] mv;
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[1:0], vld[LaneDepth-1]};
    end
  end

  assign res.valid = mv[2];
  assign res.pixel_status = octrl.status;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid)
    else $error("output dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> pix.ready)
    else $error("not ready with empty output");
  a_zero_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.pixel_status != STATUS_DECODED |-> res.phase_out == 16'd0)
    else $error("nonzero phase for undecoded pixel");
  a_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.phase_out <= OutFullScale)
    else $error("phase out of range");
`endif
endmodule

FILE: sv/fshpd_lane.sv
// One arctangent lane: pipelined vectoring CORDIC over one group of four samples.
// Depends on fshpd_pkg; one CORDIC iteration per pipeline stage.
module fshpd_lane #(
  parameter int unsigned FRAC_BITS = fshpd_pkg::DefaultFractionBits
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          samples,
  output logic [FRAC_BITS-1:0] phase,
  output logic                 flat
);
  import fshpd_pkg::*;

  logic signed [8:0] dy, dx;
  logic signed [CordicWidth-1:0] x0, y0;
  logic [31:0] z0;
  logic axis0, flat0;

  logic signed [CordicWidth-1:0] xs [CordicSteps+1];
  logic signed [CordicWidth-1:0] ys [CordicSteps+1];
  logic [31:0] zs [CordicSteps+1];
  logic [CordicSteps:0] axis_s, flat_s;
  logic [31:0] z_round;

  always_comb begin
    dy = $signed({1'b0, samples[31:24]}) - $signed({1'b0, samples[15:8]});
    dx = $signed({1'b0, samples[7:0]}) - $signed({1'b0, samples[23:16]});
    flat0 = (dx == 9'sd0) && (dy == 9'sd0);
    axis0 = (dx == 9'sd0) || (dy == 9'sd0);
    x0 = CordicWidth'(dx) <<< CordicPreshift;
    y0 = CordicWidth'(dy) <<< CordicPreshift;
    z0 = 32'd0;
    if (dy == 9'sd0) begin
      z0 = (dx > 9'sd0) ? 32'h0000_0000 : 32'h8000_0000;
    end else if (dx == 9'sd0) begin
      z0 = (dy > 9'sd0) ? 32'h4000_0000 : 32'hC000_0000;
    end else if (dx < 9'sd0) begin
      x0 = -x0;
      y0 = -y0;
      z0 = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x0;
      ys[0] <= y0;
      zs[0] <= z0;
      axis_s[0] <= axis0;
      flat_s[0] <= flat0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        axis_s[i+1] <= axis_s[i];
        flat_s[i+1] <= flat_s[i];
        if (axis_s[i]) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(5'(i));
        end
      end
    end
  end

  assign z_round = zs[CordicSteps] + (32'd1 << (31 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      phase <= z_round[31 -: FRAC_BITS];
      flat <= flat_s[CordicSteps];
    end
  end
endmodule

FILE: sv/fshpd_merge.sv
// Merging stage: heterodyne unwrapping of three lane phases and output scaling.
// Depends on fshpd_pkg; three registered stages.
module fshpd_merge #(
  parameter int unsigned FRAC_BITS = fshpd_pkg::DefaultFractionBits
) (
  input  logic                 clk,
  input  logic                 en,
  input  fshpd_pkg::ctrl_t     ctrl_in,
  input  logic [FRAC_BITS-1:0] p1,
  input  logic [FRAC_BITS-1:0] p2,
  input  logic [FRAC_BITS-1:0] p3,
  output fshpd_pkg::ctrl_t     ctrl_out,
  output logic [15:0]          phase_out
);
  import fshpd_pkg::*;

  localparam int unsigned PW = FRAC_BITS + 1;
  localparam int unsigned MW = PW + 16;

  ctrl_t c1, c2;
  logic [PW-1:0] p12, p23, p123;
  logic [MW-1:0] prod;

  function automatic logic [PW-1:0] hetero(input logic [PW-1:0] m, input logic [PW-1:0] s);
    logic [PW-1:0] r;
    r = m - s;
    if (m <= s) begin
      r = r + (PW'(1) << FRAC_BITS);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= ctrl_in;
      p12 <= hetero({1'b0, p1}, {1'b0, p2});
      p23 <= hetero({1'b0, p2}, {1'b0, p3});
      c2 <= c1;
      p123 <= hetero(p12, p23);
      ctrl_out <= c2;
      prod <= MW'(p123) * MW'(OutFullScale) + (MW'(1) << (FRAC_BITS - 1));
    end
  end

  always_comb begin
    phase_out = (ctrl_out.status == STATUS_DECODED) ? prod[FRAC_BITS +: 16] : 16'd0;
  end
endmodule
